FILE: rtl/core/cfwr_pkg.sv
// ----------------------------------------------------------------------------
// cfwr_pkg: shared types and codes for the circular FIFO with readout
// Opcodes, status codes and the command word passed from front to back.
// ----------------------------------------------------------------------------
package cfwr_pkg;

  localparam int VAL_W = 15;

  // opcodes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_READOUT = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

FILE: rtl/core/cfwr_front.sv
// ----------------------------------------------------------------------------
// cfwr_front: input side, opcode filter and command queue
// Takes input transactions, drops undefined opcodes, queues the rest.
// ----------------------------------------------------------------------------
module cfwr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   opcode,
  input  logic [cfwr_pkg::VAL_W-1:0]   push_value,
  output logic                         cmd_valid,
  output cfwr_pkg::cmd_t               cmd,
  input  logic                         cmd_take
);

  localparam int IX_W  = $clog2(cfwr_pkg::CMDQ_DEPTH);
  localparam int CNT_W = $clog2(cfwr_pkg::CMDQ_DEPTH + 1);

  cfwr_pkg::cmd_t   q [cfwr_pkg::CMDQ_DEPTH];
  logic [IX_W-1:0]  wr_ix;
  logic [IX_W-1:0]  rd_ix;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             enq;
  logic             deq;

  assign full      = (count == CNT_W'(cfwr_pkg::CMDQ_DEPTH));
  assign accept    = push && !full;
  assign enq       = accept && (opcode != cfwr_pkg::OP_NONE);
  assign cmd_valid = (count != '0);
  assign deq       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ix];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ix] <= '{op: opcode, value: push_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ix <= '0;
      rd_ix <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wr_ix <= (wr_ix == IX_W'(cfwr_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ix + IX_W'(1);
      end
      if (deq) begin
        rd_ix <= (rd_ix == IX_W'(cfwr_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ix + IX_W'(1);
      end
      count <= count + CNT_W'(enq) - CNT_W'(deq);
    end
  end

endmodule

FILE: rtl/core/cfwr_back.sv
// ----------------------------------------------------------------------------
// cfwr_back: command execution, entry store and result register
// Runs push, pop and readout on the circular store, at most one result a cycle.
// ----------------------------------------------------------------------------
module cfwr_back #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  cfwr_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   status,
  output logic [cfwr_pkg::VAL_W-1:0]   item_value,
  output logic                         last_of_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [cfwr_pkg::VAL_W-1:0] mem [DEPTH];
  logic [cfwr_pkg::VAL_W-1:0] rd_data;

  logic             state;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [OCC_W-1:0] occ;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] remaining;
  logic             is_pop;
  logic             out_valid;

  logic             slot_free;
  logic             res_load;
  logic             mem_we;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic             is_full;
  logic             is_empty;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty      = !out_valid;
  assign slot_free  = !out_valid || pop;
  assign is_full    = (occ == OCC_W'(DEPTH));
  assign is_empty   = (occ == '0);
  assign cmd_take   = (state == ST_IDLE) && cmd_valid && slot_free;
  assign mem_we     = cmd_take && (cmd.op == cfwr_pkg::OP_PUSH) && !is_full;
  assign rd_ptr_inc = ptr_inc(rd_ptr);

  // result register loads this cycle: push, empty status or a streamed entry
  assign res_load = (cmd_take && (cmd.op == cfwr_pkg::OP_PUSH ||
                     ((cmd.op == cfwr_pkg::OP_POP || cmd.op == cfwr_pkg::OP_READOUT) &&
                      is_empty))) ||
                    (state == ST_READ && slot_free);

  // read port: first entry on take, following entries while a run goes on
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (cmd_take && !is_empty &&
        (cmd.op == cfwr_pkg::OP_POP || cmd.op == cfwr_pkg::OP_READOUT)) begin
      rd_en   = 1'b1;
      rd_addr = head;
    end else if (state == ST_READ && slot_free && remaining != OCC_W'(1)) begin
      rd_en   = 1'b1;
      rd_addr = rd_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      occ       <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            unique case (cmd.op)
              cfwr_pkg::OP_PUSH: begin
                item_value  <= '0;
                last_of_run <= 1'b1;
                if (is_full) begin
                  status <= cfwr_pkg::ST_FULL;
                end else begin
                  status <= cfwr_pkg::ST_OK;
                  tail   <= ptr_inc(tail);
                  occ    <= occ + OCC_W'(1);
                end
              end
              cfwr_pkg::OP_POP, cfwr_pkg::OP_READOUT: begin
                if (is_empty) begin
                  status      <= cfwr_pkg::ST_EMPTY;
                  item_value  <= '0;
                  last_of_run <= 1'b1;
                end else begin
                  state     <= ST_READ;
                  rd_ptr    <= head;
                  is_pop    <= (cmd.op == cfwr_pkg::OP_POP);
                  remaining <= (cmd.op == cfwr_pkg::OP_POP) ? OCC_W'(1) : occ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          if (slot_free) begin
            status      <= cfwr_pkg::ST_OK;
            item_value  <= rd_data;
            last_of_run <= (remaining == OCC_W'(1));
            if (is_pop) begin
              head <= ptr_inc(head);
              occ  <= occ - OCC_W'(1);
            end
            if (remaining == OCC_W'(1)) begin
              state <= ST_IDLE;
            end else begin
              rd_ptr <= rd_ptr_inc;
            end
            remaining <= remaining - OCC_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> remaining != '0 && remaining <= occ)
    else $error("readout run length out of range");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> occ == $past(occ) + OCC_W'(1))
    else $error("store write without occupancy step");

endmodule

FILE: rtl/core/circular_fifo_with_readout.sv
// Path: a transaction is registered in the command queue; push, full and empty
//   results load when the back end takes it, pop and readout results after a
//   registered store read. Pushes flow one a cycle while results drain; a pop or
//   readout holds off new commands while its entries pass the single read port.
// Reset (rst, synchronous): store and queue pointers, occupancy, command queue
//   and result valid flag cleared; the entry store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// circular_fifo_with_readout: circular FIFO with push, pop and full readout
// Queue-style handshake on both sides; a front end filters and buffers
// commands, a back end owns the store and produces the results.
// ----------------------------------------------------------------------------
module circular_fifo_with_readout #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // input transactions
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   opcode,
  input  logic [cfwr_pkg::VAL_W-1:0]   push_value,
  // result transactions
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   status,
  output logic [cfwr_pkg::VAL_W-1:0]   item_value,
  output logic                         last_of_run
);

  // command path between the two halves
  logic           cmd_valid;
  cfwr_pkg::cmd_t cmd;
  logic           cmd_take;

  // Front end: accepts a transaction whenever its two-entry command queue
  // has room, so the input side keeps moving while a result waits.
  // Undefined opcodes are accepted and dropped here; they cause no result.
  cfwr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .push_value (push_value),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  // Back end: takes one command when idle and the result register is free
  // or being drained; a readout then streams the stored entries oldest
  // first, flagging the newest with last_of_run.
  cfwr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .item_value  (item_value),
    .last_of_run (last_of_run)
  );

endmodule
